/* sv/fct_pkg.sv */
package fct_pkg;

    // Operation codes carried on the input tuser.
    typedef enum logic [1:0] {
        OP_REC_V4 = 2'd0,
        OP_REC_V6 = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_READ   = 2'd3
    } fct_op_t;

    // Result codes carried on the output tuser.
    typedef enum logic [2:0] {
        STS_UPDATED   = 3'd0,
        STS_NEW       = 3'd1,
        STS_FULL      = 3'd2,
        STS_CLEARED   = 3'd3,
        STS_READ_OK   = 3'd4,
        STS_READ_NONE = 3'd5
    } fct_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_RESULT
    } fct_state_t;

    localparam int unsigned HITS_W = 32;

    // One stored fragment context.
    typedef struct packed {
        logic              is_v6;
        logic [31:0]       ident;
        logic [HITS_W-1:0] hits;
        logic              done;
        logic [63:0]       src_hi;
        logic [63:0]       src_lo;
        logic [63:0]       dst_hi;
        logic [63:0]       dst_lo;
    } fct_entry_t;

    // One input transaction, unpacked.
    typedef struct packed {
        fct_op_t     op;
        logic [63:0] src_hi;
        logic [63:0] src_lo;
        logic [63:0] dst_hi;
        logic [63:0] dst_lo;
        logic [31:0] frag_ident;
        logic        is_complete;
        logic [5:0]  read_slot;
    } fct_item_t;

    // One result transaction.
    typedef struct packed {
        fct_status_t status;
        logic [5:0]  slot;
        fct_entry_t  entry;
        logic [6:0]  used_entries;
    } fct_result_t;

    localparam fct_entry_t ENTRY_ZERO = '0;

endpackage

/* sv/fct_entry_mem.sv */
module fct_entry_mem
    import fct_pkg::*;
#(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  fct_entry_t    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output fct_entry_t    rd_data
);

    fct_entry_t mem [DEPTH];
    fct_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/fct_engine.sv */
module fct_engine
    import fct_pkg::*;
#(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6,
    parameter int unsigned CW    = 7
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_ready,
    input  fct_item_t     item,
    output logic          res_valid,
    input  logic          res_ready,
    output fct_result_t   res,
    output logic          mem_rd_en,
    output logic [AW-1:0] mem_rd_addr,
    input  fct_entry_t    mem_rd_data,
    output logic          mem_wr_en,
    output logic [AW-1:0] mem_wr_addr,
    output fct_entry_t    mem_wr_data
);

    localparam int unsigned CMPW = (CW > 7) ? CW : 7;

    fct_state_t    state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic          cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0] cmp_idx_reg, cmp_idx_next;
    fct_entry_t    key_reg, key_next;
    logic [5:0]    rslot_reg, rslot_next;
    fct_result_t   res_reg, res_next;

    logic          key_v6;
    logic          hit;
    logic          slot_ok;
    logic [CW-1:0] fill_inc;
    fct_entry_t    upd_entry;
    fct_entry_t    new_entry;

    // Normalized search key for a new record; it is also the new entry's image.
    always_comb
    begin
        key_v6           = (item.op == OP_REC_V6);
        key_next         = ENTRY_ZERO;
        key_next.is_v6   = key_v6;
        key_next.done    = item.is_complete;
        key_next.hits    = HITS_W'(1);
        if (key_v6)
        begin
            key_next.ident  = item.frag_ident;
            key_next.src_hi = item.src_hi;
            key_next.src_lo = item.src_lo;
            key_next.dst_hi = item.dst_hi;
            key_next.dst_lo = item.dst_lo;
        end
        else
        begin
            key_next.ident  = {16'd0, item.frag_ident[15:0]};
            key_next.src_lo = {32'd0, item.src_lo[31:0]};
            key_next.dst_lo = {32'd0, item.dst_lo[31:0]};
        end
    end

    // IPv6 entries match on identification only; IPv4 also on both addresses.
    always_comb
    begin
        if (key_reg.is_v6)
        begin
            hit = mem_rd_data.is_v6 && (mem_rd_data.ident == key_reg.ident);
        end
        else
        begin
            hit = !mem_rd_data.is_v6 && (mem_rd_data.ident == key_reg.ident)
                  && (mem_rd_data.src_lo == key_reg.src_lo)
                  && (mem_rd_data.dst_lo == key_reg.dst_lo);
        end
    end

    always_comb
    begin
        upd_entry = mem_rd_data;
        if (mem_rd_data.hits != '1)
        begin
            upd_entry.hits = mem_rd_data.hits + HITS_W'(1);
        end
        if (key_reg.done)
        begin
            upd_entry.done = 1'b1;
        end
    end

    assign new_entry = key_reg;
    assign fill_inc  = fill_reg + CW'(1);
    assign slot_ok   = (CMPW'(item.read_slot) < CMPW'(fill_reg))
                       && (CMPW'(item.read_slot) < CMPW'(DEPTH));

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        rd_idx_next  = rd_idx_reg;
        cmp_vld_next = cmp_vld_reg;
        cmp_idx_next = cmp_idx_reg;
        rslot_next   = rslot_reg;
        res_next     = res_reg;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = rd_idx_reg[AW-1:0];
        mem_wr_en    = 1'b0;
        mem_wr_addr  = cmp_idx_reg;
        mem_wr_data  = upd_entry;
        item_ready   = 1'b0;
        res_valid    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    rslot_next = item.read_slot;
                    unique case (item.op) inside
                        OP_CLEAR:
                        begin
                            fill_next             = '0;
                            res_next.status       = STS_CLEARED;
                            res_next.slot         = '0;
                            res_next.entry        = ENTRY_ZERO;
                            res_next.used_entries = '0;
                            state_next            = ST_RESULT;
                        end
                        OP_READ:
                        begin
                            if (slot_ok)
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = AW'(item.read_slot);
                                state_next  = ST_READ;
                            end
                            else
                            begin
                                res_next.status       = STS_READ_NONE;
                                res_next.slot         = item.read_slot;
                                res_next.entry        = ENTRY_ZERO;
                                res_next.used_entries = 7'(fill_reg);
                                state_next            = ST_RESULT;
                            end
                        end
                        OP_REC_V4, OP_REC_V6:
                        begin
                            rd_idx_next  = '0;
                            cmp_vld_next = 1'b0;
                            state_next   = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // Reads run one entry ahead of the compare.
                if (cmp_vld_reg && hit)
                begin
                    mem_wr_en             = 1'b1;
                    mem_wr_addr           = cmp_idx_reg;
                    mem_wr_data           = upd_entry;
                    res_next.status       = STS_UPDATED;
                    res_next.slot         = 6'(cmp_idx_reg);
                    res_next.entry        = upd_entry;
                    res_next.used_entries = 7'(fill_reg);
                    state_next            = ST_RESULT;
                end
                else if (rd_idx_reg < fill_reg)
                begin
                    mem_rd_en    = 1'b1;
                    mem_rd_addr  = rd_idx_reg[AW-1:0];
                    cmp_idx_next = rd_idx_reg[AW-1:0];
                    cmp_vld_next = 1'b1;
                    rd_idx_next  = rd_idx_reg + CW'(1);
                end
                else if (CMPW'(fill_reg) < CMPW'(DEPTH))
                begin
                    mem_wr_en             = 1'b1;
                    mem_wr_addr           = fill_reg[AW-1:0];
                    mem_wr_data           = new_entry;
                    fill_next             = fill_inc;
                    res_next.status       = STS_NEW;
                    res_next.slot         = 6'(fill_reg[AW-1:0]);
                    res_next.entry        = new_entry;
                    res_next.used_entries = 7'(fill_inc);
                    state_next            = ST_RESULT;
                end
                else
                begin
                    res_next.status       = STS_FULL;
                    res_next.slot         = '0;
                    res_next.entry        = ENTRY_ZERO;
                    res_next.used_entries = 7'(fill_reg);
                    state_next            = ST_RESULT;
                end
            end
            ST_READ:
            begin
                res_next.status       = STS_READ_OK;
                res_next.slot         = rslot_reg;
                res_next.entry        = mem_rd_data;
                res_next.used_entries = 7'(fill_reg);
                state_next            = ST_RESULT;
            end
            ST_RESULT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            rd_idx_reg  <= '0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            rd_idx_reg  <= rd_idx_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        rslot_reg   <= rslot_next;
        res_reg     <= res_next;
        if (state_reg == ST_IDLE && item_valid)
        begin
            key_reg <= key_next;
        end
    end

    assign res = res_reg;

endmodule

/* sv/fragment_context_table.sv */
// Channel   Direction  tuser                 tdata
// s_axis    in         op (2 bits)           addresses, identification, completion, read slot
// m_axis    out        status (3 bits)       slot, stored entry, used entry count
//
// A record transaction reads one entry per cycle in arrival order up to the
// fill level, all used slots for a new context or a full table. A read of a
// valid slot passes ST_READ before its result; a clear or a read of an unused
// slot goes straight to the result. Reset empties the table through the fill
// counter alone. The input waits while a transaction is in work; the output
// register frees the engine while a result still waits on m_axis_tready.
module fragment_context_table
    import fct_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tuser: op [1:0].
    input  logic [1:0]   s_axis_tuser,
    // tdata from bit 0: src_hi, src_lo, dst_hi, dst_lo, frag_ident,
    // is_complete, read_slot, one zero pad bit.
    input  logic [295:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tuser: status [2:0].
    output logic [2:0]   m_axis_tuser,
    // tdata from bit 0: slot, entry_is_v6, entry_ident, entry_hits,
    // entry_done, entry_src_hi, entry_src_lo, entry_dst_hi, entry_dst_lo,
    // used_entries, one zero pad bit.
    output logic [335:0] m_axis_tdata
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    fct_item_t     item;
    fct_result_t   res;
    logic          res_valid;
    logic          res_ready;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    fct_entry_t    mem_rd_data;
    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    fct_entry_t    mem_wr_data;

    logic          out_valid_reg;
    fct_result_t   out_reg;

    // Unpack the input transaction.
    always_comb
    begin
        item.op          = fct_op_t'(s_axis_tuser);
        item.src_hi      = s_axis_tdata[63:0];
        item.src_lo      = s_axis_tdata[127:64];
        item.dst_hi      = s_axis_tdata[191:128];
        item.dst_lo      = s_axis_tdata[255:192];
        item.frag_ident  = s_axis_tdata[287:256];
        item.is_complete = s_axis_tdata[288];
        item.read_slot   = s_axis_tdata[294:289];
    end

    fct_engine #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (s_axis_tvalid),
        .item_ready  (s_axis_tready),
        .item        (item),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

    fct_entry_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_entry_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Output register: a finished result moves here so the engine is free.
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {1'b0,
                            out_reg.used_entries,
                            out_reg.entry.dst_lo,
                            out_reg.entry.dst_hi,
                            out_reg.entry.src_lo,
                            out_reg.entry.src_hi,
                            out_reg.entry.done,
                            out_reg.entry.hits,
                            out_reg.entry.ident,
                            out_reg.entry.is_v6,
                            out_reg.slot};

endmodule
